[rtl/core/kgsr_pkg.sv]
// Shared constants and control/status types for the k-group stream reverser.
// No dependencies; compiled first.
`timescale 1ns / 1ps
package kgsr_pkg;

  localparam int unsigned MAX_GROUP_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned GSIZE_W       = 5;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned REG_IDX_W     = 1;

  localparam logic [GSIZE_W-1:0]   GSIZE_RST      = 5'd2;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE = 1'd0;

  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flush;
    logic last;
    logic slot_free;
  } dp_status_t;

endpackage

[rtl/core/kgsr_in_if.sv]
// Input channel interface: valid/ready with one list element per transaction.
// Depends on kgsr_pkg.
`timescale 1ns / 1ps
interface kgsr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kgsr_pkg::DATA_W-1:0]   value;
  logic                                 list_end;

  modport source (output valid, output value, output list_end, input ready);
  modport sink   (input valid, input value, input list_end, output ready);
endinterface

[rtl/core/kgsr_out_if.sv]
// Output channel interface: valid/ready with one reordered element per transaction.
// Depends on kgsr_pkg.
`timescale 1ns / 1ps
interface kgsr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kgsr_pkg::DATA_W-1:0]   out_value;
  logic                                 run_last;
  logic                                 out_list_end;

  modport source (output valid, output out_value, output run_last, output out_list_end,
                  input ready);
  modport sink   (input valid, input out_value, input run_last, input out_list_end,
                  output ready);
endinterface

[rtl/core/kgsr_regs.sv]
// APB-style configuration register file holding group_size.
// Depends on kgsr_pkg.
`timescale 1ns / 1ps
module kgsr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kgsr_pkg::APB_AW-1:0]   paddr,
  input  logic [kgsr_pkg::APB_DW-1:0]   pwdata,
  output logic [kgsr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [kgsr_pkg::GSIZE_W-1:0]  group_size_o
);

  logic [kgsr_pkg::GSIZE_W-1:0] group_size_q, group_size_d;
  logic                         sel_gsize;

  assign sel_gsize = (paddr[kgsr_pkg::APB_AW-1:2] == kgsr_pkg::REG_GROUP_SIZE);
  assign pready    = 1'b1;

  always_comb begin
    group_size_d = group_size_q;
    if (psel && penable && pwrite && sel_gsize) begin
      group_size_d = pwdata[kgsr_pkg::GSIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_gsize) begin
      prdata = {{(kgsr_pkg::APB_DW-kgsr_pkg::GSIZE_W){1'b0}}, group_size_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= kgsr_pkg::GSIZE_RST;
    end else begin
      group_size_q <= group_size_d;
    end
  end

  assign group_size_o = group_size_q;

endmodule

[rtl/core/kgsr_dp.sv]
// Datapath: group buffer memory, fill and read counters, output register.
// Depends on kgsr_pkg; driven by kgsr_ctrl through ctrl_cmd_t.
`timescale 1ns / 1ps
module kgsr_dp #(
  parameter int unsigned MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [kgsr_pkg::GSIZE_W-1:0]        group_size_i,
  input  logic signed [kgsr_pkg::DATA_W-1:0]  value_i,
  input  logic                                list_end_i,
  input  kgsr_pkg::ctrl_cmd_t                 cmd_i,
  output kgsr_pkg::dp_status_t                status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [kgsr_pkg::DATA_W-1:0]  out_value_o,
  output logic                                run_last_o,
  output logic                                out_list_end_o
);

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam int unsigned KW = (CW > kgsr_pkg::GSIZE_W) ? CW : kgsr_pkg::GSIZE_W;

  logic [kgsr_pkg::DATA_W-1:0] mem_q [MAX_GROUP];

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] left_q, left_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          rev_q, rev_d;
  logic          end_q, end_d;
  logic          out_valid_q, out_valid_d;

  logic signed [kgsr_pkg::DATA_W-1:0] out_value_q;
  logic                               run_last_q;
  logic                               out_list_end_q;

  logic [KW-1:0] k_eff;
  logic [CW-1:0] n_new;
  logic          rev_now;
  logic          last_now;

  always_comb begin
    if (group_size_i <= kgsr_pkg::GSIZE_W'(1)) begin
      k_eff = KW'(1);
    end else if (KW'(group_size_i) > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = KW'(group_size_i);
    end
  end

  assign n_new    = fill_q + CW'(1);
  assign rev_now  = (KW'(n_new) >= k_eff);
  assign last_now = (left_q == CW'(1));

  assign status_o.flush     = rev_now || list_end_i;
  assign status_o.last      = last_now;
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    fill_d      = fill_q;
    left_d      = left_q;
    rd_addr_d   = rd_addr_q;
    rev_d       = rev_q;
    end_d       = end_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.accept) begin
      if (rev_now || list_end_i) begin
        fill_d    = '0;
        left_d    = n_new;
        rev_d     = rev_now;
        end_d     = list_end_i;
        rd_addr_d = rev_now ? fill_q[AW-1:0] : '0;
      end else begin
        fill_d = n_new;
      end
    end
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
      left_d      = left_q - CW'(1);
      rd_addr_d   = rev_q ? (rd_addr_q - AW'(1)) : (rd_addr_q + AW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      left_q      <= '0;
      rd_addr_q   <= '0;
      rev_q       <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      left_q      <= left_d;
      rd_addr_q   <= rd_addr_d;
      rev_q       <= rev_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[fill_q[AW-1:0]] <= value_i;
    end
    if (cmd_i.load) begin
      out_value_q    <= $signed(mem_q[rd_addr_q]);
      run_last_q     <= last_now;
      out_list_end_q <= last_now && end_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign run_last_o     = run_last_q;
  assign out_list_end_o = out_list_end_q;

endmodule

[rtl/core/kgsr_ctrl.sv]
// Controller: takes input transactions while idle and sequences group read-out.
// Depends on kgsr_pkg; commands kgsr_dp.
`timescale 1ns / 1ps
module kgsr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kgsr_pkg::dp_status_t status_i,
  output kgsr_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.load   = (state_q == ST_EMIT) && status_i.slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept && status_i.flush) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd_o.load && status_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/k_group_stream_reverser.sv]
// k-group stream reverser top level: APB registers, controller and datapath.
// Depends on kgsr_pkg, kgsr_in_if, kgsr_out_if, kgsr_regs, kgsr_ctrl, kgsr_dp.
//
// Usage: list elements arrive on in_i (valid/ready), the final one flagged by
// list_end. Elements are buffered until group_size of them are held, then the
// group leaves on out_o in reversed order; a list that ends short of a full
// group leaves in arrival order. group_size 0 or 1 passes elements through.
// run_last marks the last result of a burst, out_list_end the end of a list.
// Read-out: an input that completes a group of n elements is followed by
// read-out of all n, one result per cycle while the receiver does not stall,
// through the single buffer read port into the output register; input is held
// off meanwhile. The first result reaches out_o via the ST_EMIT state register
// and then the output register.
// A stalled receiver holds the output register and pauses read-out; the next
// input is taken while the final result of a burst still waits.
// Reset: group_size returns to 2 and the fill count clears; no clearing pass.
// Write group_size (register 0, byte address 0) only while idle; not enforced.
`timescale 1ns / 1ps
module k_group_stream_reverser #(
  parameter int unsigned MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kgsr_in_if.sink                       in_i,
  kgsr_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kgsr_pkg::APB_AW-1:0]   paddr,
  input  logic [kgsr_pkg::APB_DW-1:0]   pwdata,
  output logic [kgsr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [kgsr_pkg::GSIZE_W-1:0] group_size;
  kgsr_pkg::ctrl_cmd_t          cmd;
  kgsr_pkg::dp_status_t         status;

  kgsr_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .group_size_o (group_size)
  );

  kgsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kgsr_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_size_i   (group_size),
    .value_i        (in_i.value),
    .list_end_i     (in_i.list_end),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_value_o    (out_o.out_value),
    .run_last_o     (out_o.run_last),
    .out_list_end_o (out_o.out_list_end)
  );

  a_end_has_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_list_end |-> out_o.run_last)
    else $error("out_list_end without run_last");

  a_no_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !cmd.load)
    else $error("read-out overlaps input transaction");

  a_flush_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept && status.flush |=> !in_i.ready)
    else $error("flush did not start read-out");

  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> out_o.valid)
    else $error("load did not fill output register");

endmodule

[tb/k_group_stream_reverser_tb.sv]
// Self-checking bench for the k-group stream reverser: drives element lists over the
// input channel, programs group_size over APB and checks every reordered transaction.
// Depends on kgsr_pkg, kgsr_in_if, kgsr_out_if and the k_group_stream_reverser RTL.
`timescale 1ns / 1ps
module k_group_stream_reverser_tb;

  localparam int unsigned GROUP_CAP      = kgsr_pkg::MAX_GROUP_DEF;
  localparam int unsigned RANDOM_ITEMS   = 480;
  localparam int unsigned MAX_IDLE       = 18;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned REPORT_CAP     = 100;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam logic [kgsr_pkg::APB_AW-1:0] GROUP_SIZE_ADDR = {kgsr_pkg::REG_GROUP_SIZE, 2'b00};

  typedef struct packed {
    logic signed [kgsr_pkg::DATA_W-1:0] value;
    logic                               list_end;
  } element_t;

  typedef struct packed {
    logic signed [kgsr_pkg::DATA_W-1:0] value;
    logic                               run_last;
    logic                               list_end;
  } reordered_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [kgsr_pkg::APB_AW-1:0] paddr;
  logic [kgsr_pkg::APB_DW-1:0] pwdata;
  logic [kgsr_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  kgsr_in_if  in_ch ();
  kgsr_out_if out_ch ();

  k_group_stream_reverser u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reference state of the reorder buffer
  logic [kgsr_pkg::DATA_W-1:0]  group_store [GROUP_CAP];
  int unsigned                  held_count;
  logic [kgsr_pkg::GSIZE_W-1:0] group_size_q;
  reordered_t                   reordered_q [$];

  element_t    element_q [$];
  element_t    cur_element;
  bit          send_busy;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned sender_max_gap;
  int unsigned receiver_max_stall;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned queued_items;
  int unsigned lists_closed;
  int unsigned elements_taken;
  int unsigned results_seen;
  int unsigned size_writes;

  function automatic int unsigned effective_run(input logic [kgsr_pkg::GSIZE_W-1:0] gs);
    if (gs <= 1) return 1;
    if (gs > GROUP_CAP) return GROUP_CAP;
    return 32'(gs);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic absorb_element(input logic [kgsr_pkg::DATA_W-1:0] v, input logic is_end);
    int unsigned k;
    int unsigned n;
    int unsigned i;
    bit          reverse;
    reordered_t  r;
    k = effective_run(group_size_q);
    if (held_count >= GROUP_CAP) held_count = GROUP_CAP - 1;
    group_store[held_count] = v;
    held_count++;
    n = held_count;
    reverse = (n >= k);
    if (reverse || is_end) begin
      for (i = 0; i < n; i++) begin
        r.value    = reverse ? group_store[n - 1 - i] : group_store[i];
        r.run_last = (i + 1 == n);
        r.list_end = r.run_last && is_end;
        reordered_q.push_back(r);
      end
      held_count = 0;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
  end

  // Monitor: absorb accepted elements, check reordered transactions
  always @(posedge clk_i) begin
    reordered_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_element(in_ch.value, in_ch.list_end);
        elements_taken++;
        send_busy = 1'b0;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (reordered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d run_last=%b list_end=%b",
                                    out_ch.out_value, out_ch.run_last, out_ch.out_list_end));
        end else begin
          want = reordered_q.pop_front();
          if (out_ch.out_value !== want.value || out_ch.run_last !== want.run_last ||
              out_ch.out_list_end !== want.list_end) begin
            report_mismatch($sformatf({"result %0d: value=%0d/%0d run_last=%b/%b ",
                                       "list_end=%b/%b (got/want)"}, results_seen,
                                      out_ch.out_value, want.value, out_ch.run_last,
                                      want.run_last, out_ch.out_list_end, want.list_end));
          end
        end
        stall_left = $urandom_range(0, receiver_max_stall);
      end
    end
  end

  // Driver: feed the input channel from the element queue with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!send_busy) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (element_q.size() > 0) begin
        cur_element = element_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.value    <= cur_element.value;
        in_ch.list_end <= cur_element.list_end;
        send_busy = 1'b1;
        gap_left  = $urandom_range(0, sender_max_gap);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall after each transaction for the drawn number of cycles
  always @(negedge clk_i) begin
    if (rst_ni && stall_left == 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      if (rst_ni) stall_left--;
    end
  end

  task automatic wait_quiet();
    while (element_q.size() != 0 || send_busy || reordered_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic read_group_size(output logic [kgsr_pkg::APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= GROUP_SIZE_ADDR;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_group_size(input logic [kgsr_pkg::GSIZE_W-1:0] gs);
    logic [kgsr_pkg::APB_DW-1:0] rdata;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= GROUP_SIZE_ADDR;
    pwdata  <= kgsr_pkg::APB_DW'(gs);
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    group_size_q = gs;
    size_writes++;
    read_group_size(rdata);
    if (rdata !== kgsr_pkg::APB_DW'(gs))
      report_mismatch($sformatf("group_size read back %0d, wrote %0d", rdata, gs));
  endtask

  task automatic push_element(input logic [kgsr_pkg::DATA_W-1:0] v, input logic is_end);
    element_t e;
    e.value    = v;
    e.list_end = is_end;
    element_q.push_back(e);
    queued_items++;
    if (is_end) lists_closed++;
  endtask

  task automatic push_list(input int unsigned len, input bit closed);
    int unsigned i;
    logic [kgsr_pkg::DATA_W-1:0] v;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = '0;
        3:       v = '1;
        default: v = $urandom;
      endcase
      push_element(v, closed && (i + 1 == len));
    end
  endtask

  initial begin
    logic [kgsr_pkg::APB_DW-1:0]  rdata;
    logic [kgsr_pkg::GSIZE_W-1:0] gsize;
    int unsigned                  run_len;
    int unsigned                  directed_items;
    int unsigned                  list_len;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.list_end = 1'b0;
    out_ch.ready   = 1'b0;
    group_size_q   = kgsr_pkg::GSIZE_RST;
    held_count     = 0;
    sender_max_gap     = MAX_IDLE;
    receiver_max_stall = MAX_IDLE;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    read_group_size(rdata);
    if (rdata !== kgsr_pkg::APB_DW'(kgsr_pkg::GSIZE_RST))
      report_mismatch($sformatf("group_size after reset reads %0d", rdata));

    // Reset size: two full pairs with the list closing on a full group, then a lone end
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h7fff_ffff, 1'b0);
    push_element(32'h0000_0000, 1'b0);
    push_element(32'hffff_ffff, 1'b1);
    push_element(32'd5, 1'b1);
    wait_quiet();
    write_group_size(kgsr_pkg::GSIZE_W'(0));
    push_element(32'd1, 1'b0);
    push_element(32'd2, 1'b1);
    wait_quiet();
    write_group_size(kgsr_pkg::GSIZE_W'(1));
    push_element(32'd3, 1'b1);
    wait_quiet();
    // Hold three elements, then shrink the group mid-list
    write_group_size(kgsr_pkg::GSIZE_W'(5));
    push_element(32'd10, 1'b0);
    push_element(32'd11, 1'b0);
    push_element(32'd12, 1'b0);
    wait_quiet();
    write_group_size(kgsr_pkg::GSIZE_W'(2));
    push_element(32'd13, 1'b0);
    wait_quiet();
    write_group_size({kgsr_pkg::GSIZE_W{1'b1}});
    push_element(32'd20, 1'b0);
    push_element(32'd21, 1'b0);
    push_element(32'd22, 1'b1);
    wait_quiet();
    write_group_size(kgsr_pkg::GSIZE_W'(3));
    push_element(32'h5555_5555, 1'b0);
    push_element(32'haaaa_aaaa, 1'b0);
    push_element(32'd30, 1'b1);
    wait_quiet();
    directed_items = queued_items;

    while (queued_items < directed_items + RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       gsize = kgsr_pkg::GSIZE_W'($urandom_range(0, 1));
        1:       gsize = kgsr_pkg::GSIZE_W'($urandom_range(GROUP_CAP + 1,
                                                           (1 << kgsr_pkg::GSIZE_W) - 1));
        2:       gsize = kgsr_pkg::GSIZE_W'(GROUP_CAP);
        default: gsize = kgsr_pkg::GSIZE_W'($urandom_range(2, GROUP_CAP - 1));
      endcase
      write_group_size(gsize);
      run_len            = effective_run(gsize);
      sender_max_gap     = $urandom_range(0, 1) ? MAX_IDLE : 0;
      receiver_max_stall = $urandom_range(0, 1) ? MAX_IDLE : 0;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1))
          list_len = run_len * $urandom_range(1, 3);
        else
          list_len = $urandom_range(1, 2 * run_len + 3);
        push_list(list_len, 1'b1);
      end
      // Leave a list open across the next size change
      if ($urandom_range(0, 2) == 0) push_list($urandom_range(1, run_len), 1'b0);
      wait_quiet();
    end

    push_list(1, 1'b1);
    wait_quiet();
    if (reordered_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", reordered_q.size()));

    $display("covered %0d elements in %0d closed lists, %0d results checked",
             elements_taken, lists_closed, results_seen);
    $display("group_size programmed %0d times, %0d mismatches", size_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
